// File: rtl/mbtcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbtcf_pkg
// Shared types and constants for the matroid basis test against a table of
// cyclic flats: item and result layouts, table sizes, mode and register codes.
// ----------------------------------------------------------------------------
package mbtcf_pkg;

  // ground set and table sizes
  localparam int MAX_ELEMENTS = 64;
  localparam int MAX_FLATS    = 64;
  localparam int SET_W        = 64;
  localparam int RANK_W       = 7;
  localparam int FLAT_AW      = (MAX_FLATS > 1) ? $clog2(MAX_FLATS) : 1;
  localparam int CNT_W        = $clog2(MAX_FLATS + 1);
  localparam int ENTRY_W      = SET_W + RANK_W;

  // reported flat index codes
  localparam logic [RANK_W-1:0] NONE_VIOLATED = 7'd64;
  localparam logic [RANK_W-1:0] BEYOND_REPORT = 7'd127;

  // item modes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_TEST   = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASIS_RANK    = 1'd1;

  // reset values of the configuration registers
  localparam logic [RANK_W-1:0] ELEMENT_COUNT_RST = 7'd64;
  localparam logic [RANK_W-1:0] BASIS_RANK_RST    = 7'd0;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SET_W-1:0]  element_set;
    logic [RANK_W-1:0] flat_rank;
  } item_t;

  typedef struct packed {
    logic              is_basis;
    logic              wrong_size;
    logic [RANK_W-1:0] violated_flat;
    logic              dropped_loads;
  } result_t;

endpackage

// File: rtl/mbtcf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbtcf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mbtcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/matroid_basis_test_cyclic_flats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matroid_basis_test_cyclic_flats
// Keeps a table of cyclic flats (mask and rank) in one RAM and tests
// candidate sets against size, ground set and every stored flat bound.
// ----------------------------------------------------------------------------
// Busy stays low for clear and append items.
// A test strobes its result when its scan of the stored flats ends, early
// on a violated flat: one flat per cycle through the single RAM read port,
// busy high during the scan. The next item is taken in the cycle the result
// shows; the receiver cannot stall. Sync reset: empty table, dropped flag
// low, element_count 64, rank 0.
module matroid_basis_test_cyclic_flats
  import mbtcf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item,
  output logic                 result_valid,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RANK_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  // adder tree population count
  function automatic logic [6:0] popcnt64(input logic [63:0] v);
    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];
    for (int i = 0; i < 32; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    return {1'b0, l5[0]} + {1'b0, l5[1]};
  endfunction

  state_t              state;
  logic [RANK_W-1:0]   element_count;
  logic [RANK_W-1:0]   basis_rank;
  logic [CNT_W-1:0]    flat_count;
  logic                overflow;
  logic [SET_W-1:0]    cand;
  logic                wrong;
  logic [CNT_W-1:0]    rd_idx;
  logic                chk_valid;
  logic [FLAT_AW-1:0]  chk_idx;

  logic                accept;
  logic                rd_issue;
  logic                ram_we;
  logic [ENTRY_W-1:0]  rd_entry;
  logic [SET_W-1:0]    rd_mask;
  logic [RANK_W-1:0]   rd_rank;
  logic                hit;
  logic                scan_end;
  logic [RANK_W-1:0]   ec_cap;
  logic [SET_W-1:0]    vmask;
  logic                wrong_next;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // ground set mask from the capped element count
  always_comb begin
    ec_cap = (element_count > RANK_W'(MAX_ELEMENTS)) ? RANK_W'(MAX_ELEMENTS)
                                                     : element_count;
    for (int i = 0; i < SET_W; i++) vmask[i] = (RANK_W'(i) < ec_cap);
  end

  assign wrong_next = (popcnt64(item.element_set) != basis_rank) ||
                      ((item.element_set & ~vmask) != '0);

  // flat table: mask and rank share one entry; appends only happen when
  // idle and reads only during the scan, so accesses never overlap
  assign ram_we = accept && (item.mode == MODE_APPEND) &&
                  (flat_count != CNT_W'(MAX_FLATS));

  assign rd_issue = (state == S_SCAN) && (rd_idx < flat_count);

  mbtcf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_FLATS)
  ) u_flat_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (flat_count[FLAT_AW-1:0]),
    .wdata ({item.element_set, item.flat_rank}),
    .re    (rd_issue),
    .raddr (rd_idx[FLAT_AW-1:0]),
    .rdata (rd_entry)
  );

  assign rd_mask = rd_entry[ENTRY_W-1:RANK_W];
  assign rd_rank = rd_entry[RANK_W-1:0];

  // flat bound check on the entry read last cycle
  assign hit      = chk_valid && (popcnt64(cand & rd_mask) > rd_rank);
  assign scan_end = (state == S_SCAN) && (hit || (!rd_issue && !chk_valid));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= ELEMENT_COUNT_RST;
      basis_rank    <= BASIS_RANK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ELEMENT_COUNT: element_count <= cfg_data;
        REG_BASIS_RANK:    basis_rank    <= cfg_data;
        default: ;
      endcase
    end
  end

  // table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      flat_count <= '0;
      overflow   <= 1'b0;
    end else if (accept) begin
      case (item.mode)
        MODE_CLEAR: begin
          flat_count <= '0;
          overflow   <= 1'b0;
        end
        MODE_APPEND: begin
          if (flat_count == CNT_W'(MAX_FLATS)) overflow <= 1'b1;
          else flat_count <= flat_count + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      chk_valid    <= 1'b0;
      rd_idx       <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && (item.mode == MODE_TEST)) begin
            state     <= S_SCAN;
            rd_idx    <= '0;
            chk_valid <= 1'b0;
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state        <= S_IDLE;
            chk_valid    <= 1'b0;
            result_valid <= 1'b1;
          end else begin
            chk_valid <= rd_issue;
            if (rd_issue) rd_idx <= rd_idx + CNT_W'(1);
          end
        end
        default: begin
          state     <= S_IDLE;
          chk_valid <= 1'b0;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && (item.mode == MODE_TEST)) begin
      cand  <= item.element_set;
      wrong <= wrong_next;
    end
    if (rd_issue) chk_idx <= rd_idx[FLAT_AW-1:0];
    if (scan_end) begin
      result.wrong_size    <= wrong;
      result.dropped_loads <= overflow;
      if (hit) begin
        result.is_basis      <= 1'b0;
        result.violated_flat <= ({1'b0, chk_idx} < (FLAT_AW+1)'(64))
                                ? RANK_W'(chk_idx) : BEYOND_REPORT;
      end else begin
        result.is_basis      <= !wrong;
        result.violated_flat <= NONE_VIOLATED;
      end
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    flat_count <= CNT_W'(MAX_FLATS))
    else $error("flat count beyond table depth");

  a_result_after_scan: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a scan");

  a_table_frozen: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(flat_count) && $stable(overflow))
    else $error("table changed during a scan");

  a_check_in_table: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> ({1'b0, chk_idx} < flat_count))
    else $error("checked entry beyond stored flats");

  a_basis_consistent: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.is_basis ==
      (!result.wrong_size && (result.violated_flat == NONE_VIOLATED))))
    else $error("basis flag disagrees with size and flat checks");

endmodule

// File: tb/sv/matroid_basis_test_cyclic_flats_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matroid_basis_test_cyclic_flats_tb
// Self-checking bench for the cyclic flat basis tester. A short directed table
// covers the reset state, the field extremes and the ignored mode. Random
// clear, load and test sequences follow under several register settings and
// sender gap profiles. Each result is checked against a local model of the
// flat table, or against the expected result that a typed directed row gives.
// ----------------------------------------------------------------------------
module matroid_basis_test_cyclic_flats_tb;
  import mbtcf_pkg::*;

  // mode code the block ignores
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 250;
  localparam int TOTAL_ITEMS = PHASES * PHASE_ITEMS;
  localparam int SETTLE_CYCLES = MAX_FLATS + 8;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  item_t                item;
  logic                 result_valid;
  result_t              result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RANK_W-1:0]    cfg_data;

  // local copy of the flat table and registers
  logic [SET_W-1:0]  flat_mask_q [MAX_FLATS];
  logic [RANK_W-1:0] flat_rank_q [MAX_FLATS];
  int                flat_total = 0;
  bit                overflow_seen = 1'b0;
  int                elem_count_cfg = ELEMENT_COUNT_RST;
  int                basis_rank_cfg = BASIS_RANK_RST;

  result_t pending_results[$];
  row_t    dir_rows[$];
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      idle_pct = 0;

  matroid_basis_test_cyclic_flats dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic flag_error(string msg);
    $display("%0t ERROR %s", $time, msg);
    mismatch_count++;
  endtask

  // elements below the configured ground set size
  function automatic logic [SET_W-1:0] valid_bits();
    int n;
    n = (elem_count_cfg > MAX_ELEMENTS) ? MAX_ELEMENTS : elem_count_cfg;
    if (n >= SET_W) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // apply one accepted item to the local table, return 1 when it gives a result
  function automatic bit predict_item(item_t it, output result_t r);
    bit wrong;
    int viol;
    r = '0;
    case (it.mode)
      MODE_CLEAR: begin
        flat_total = 0;
        overflow_seen = 1'b0;
        return 1'b0;
      end
      MODE_APPEND: begin
        if (flat_total >= MAX_FLATS) begin
          overflow_seen = 1'b1;
        end else begin
          flat_mask_q[flat_total] = it.element_set;
          flat_rank_q[flat_total] = it.flat_rank;
          flat_total++;
        end
        return 1'b0;
      end
      MODE_TEST: begin
        wrong = ($countones(it.element_set) != basis_rank_cfg) ||
                ((it.element_set & ~valid_bits()) != '0);
        viol = NONE_VIOLATED;
        for (int i = 0; i < flat_total; i++) begin
          if ($countones(it.element_set & flat_mask_q[i]) > flat_rank_q[i]) begin
            viol = (i < 64) ? i : BEYOND_REPORT;
            break;
          end
        end
        r.is_basis      = !wrong && (viol == NONE_VIOLATED);
        r.wrong_size    = wrong;
        r.violated_flat = viol[RANK_W-1:0];
        r.dropped_loads = overflow_seen;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic item_t mk_item(logic [1:0] m, logic [SET_W-1:0] s, logic [RANK_W-1:0] rk);
    item_t it;
    it.mode        = m;
    it.element_set = s;
    it.flat_rank   = rk;
    return it;
  endfunction

  function automatic row_t mk_row(logic [1:0] m, logic [SET_W-1:0] s, logic [RANK_W-1:0] rk,
                                  bit typed, bit b, bit w, logic [RANK_W-1:0] v, bit d);
    row_t row;
    row.it                 = mk_item(m, s, rk);
    row.typed              = typed;
    row.want.is_basis      = b;
    row.want.wrong_size    = w;
    row.want.violated_flat = v;
    row.want.dropped_loads = d;
    return row;
  endfunction

  // append one row to the directed table
  task automatic add_row(row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endtask

  function automatic logic [SET_W-1:0] rand_set();
    return {$urandom, $urandom};
  endfunction

  // random set of k elements among the lowest n
  function automatic logic [SET_W-1:0] subset_of_size(int n, int k);
    logic [SET_W-1:0] s;
    s = '0;
    if (k > n) k = n;
    while ($countones(s) < k) s[$urandom_range(n - 1)] = 1'b1;
    return s;
  endfunction

  function automatic int ground_size();
    return (elem_count_cfg > MAX_ELEMENTS) ? MAX_ELEMENTS : elem_count_cfg;
  endfunction

  // offer one item, wait for it to be taken, then maybe leave a gap
  task automatic send(item_t it, bit typed, result_t want);
    result_t pred;
    int gap;
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (predict_item(it, pred))
      pending_results.insert(pending_results.size(), typed ? want : pred);
    if (it.mode != MODE_UNUSED) items_sent++;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering, wait for all results and let appends settle
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both registers back to back, valid held across them
  task automatic load_setting(int ec, int br);
    logic [RANK_W-1:0] vals [2];
    vals[0] = ec[RANK_W-1:0];
    vals[1] = br[RANK_W-1:0];
    cfg_valid <= 1'b1;
    for (int i = 0; i < 2; i++) begin
      cfg_index <= (i == 0) ? REG_ELEMENT_COUNT : REG_BASIS_RANK;
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    elem_count_cfg = vals[0];
    basis_rank_cfg = vals[1];
  endtask

  // one well-formed sequence: optional clear, some flats, some candidates
  task automatic run_sequence();
    int n, nf, nt, s, pick;
    logic [RANK_W-1:0] rk;
    logic [SET_W-1:0] cand;
    n = ground_size();
    if ($urandom_range(99) < 80)
      send(mk_item(MODE_CLEAR, rand_set(), RANK_W'($urandom)), 1'b0, '0);
    pick = $urandom_range(99);
    if (pick < 85) nf = $urandom_range(0, 8);
    else if (pick < 95) nf = $urandom_range(9, 40);
    else nf = $urandom_range(60, 70);
    for (int i = 0; i < nf; i++) begin
      s = $urandom_range(0, n);
      case ($urandom_range(3))
        0: rk = RANK_W'(s);
        1: rk = RANK_W'((s > 0) ? s - 1 : 0);
        2: rk = RANK_W'($urandom_range(0, s));
        default: rk = RANK_W'(s / 2);
      endcase
      send(mk_item(MODE_APPEND, subset_of_size(n, s), rk), 1'b0, '0);
    end
    nt = $urandom_range(1, 6);
    for (int i = 0; i < nt; i++) begin
      cand = subset_of_size(n, basis_rank_cfg);
      pick = $urandom_range(99);
      if (pick >= 93) cand = rand_set();
      else if (pick >= 85) cand[$urandom_range(SET_W - 1)] ^= 1'b1;
      send(mk_item(MODE_TEST, cand, RANK_W'($urandom)), 1'b0, '0);
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        flag_error("result with no test pending");
      end else begin
        want = pending_results.pop_front();
        if (result.is_basis !== want.is_basis)
          flag_error($sformatf("is_basis got %b want %b", result.is_basis, want.is_basis));
        if (result.wrong_size !== want.wrong_size)
          flag_error($sformatf("wrong_size got %b want %b",
                               result.wrong_size, want.wrong_size));
        if (result.violated_flat !== want.violated_flat)
          flag_error($sformatf("violated_flat got %0d want %0d",
                               result.violated_flat, want.violated_flat));
        if (result.dropped_loads !== want.dropped_loads)
          flag_error($sformatf("dropped_loads got %b want %b",
                               result.dropped_loads, want.dropped_loads));
      end
    end
  end

  // stimulus
  initial begin
    int ec_list [PHASES];
    int br_list [PHASES];
    int phase_end;
    item_t it;
    ec_list = '{64, 1, 0, 127, 12, 64, 33};
    br_list = '{5, 1, 0, 127, 6, 64, 16};

    start     <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ELEMENT_COUNT;
    cfg_data  <= '0;
    rst       <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed rows at reset values: element_count 64, basis_rank 0
    add_row(mk_row(MODE_TEST, 64'h0, 7'd0, 1'b1, 1'b1, 1'b0, NONE_VIOLATED, 1'b0));
    add_row(mk_row(MODE_TEST, '1, 7'd127, 1'b1, 1'b0, 1'b1, NONE_VIOLATED, 1'b0));
    add_row(mk_row(MODE_UNUSED, '1, 7'd127, 1'b0, 1'b0, 1'b0, '0, 1'b0));
    add_row(mk_row(MODE_APPEND, '1, 7'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0));
    add_row(mk_row(MODE_TEST, 64'h0, 7'd0, 1'b1, 1'b1, 1'b0, NONE_VIOLATED, 1'b0));
    add_row(mk_row(MODE_TEST, 64'h8000_0000_0000_0000, 7'd0,
                   1'b1, 1'b0, 1'b1, 7'd0, 1'b0));
    add_row(mk_row(MODE_APPEND, 64'h0, 7'd127, 1'b0, 1'b0, 1'b0, '0, 1'b0));
    add_row(mk_row(MODE_APPEND, '1, 7'd64, 1'b0, 1'b0, 1'b0, '0, 1'b0));
    add_row(mk_row(MODE_TEST, 64'h0, 7'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0));
    add_row(mk_row(MODE_CLEAR, '1, 7'd127, 1'b0, 1'b0, 1'b0, '0, 1'b0));
    add_row(mk_row(MODE_TEST, '1, 7'd0, 1'b1, 1'b0, 1'b1, NONE_VIOLATED, 1'b0));
    add_row(mk_row(MODE_APPEND, 64'h0000_0000_0000_000F, 7'd2,
                   1'b0, 1'b0, 1'b0, '0, 1'b0));
    add_row(mk_row(MODE_APPEND, 64'hF000_0000_0000_0000, 7'd1,
                   1'b0, 1'b0, 1'b0, '0, 1'b0));
    add_row(mk_row(MODE_TEST, 64'h0000_0000_0000_0003, 7'd0,
                   1'b0, 1'b0, 1'b0, '0, 1'b0));
    add_row(mk_row(MODE_TEST, 64'h0000_0000_0000_0007, 7'd0,
                   1'b0, 1'b0, 1'b0, '0, 1'b0));
    add_row(mk_row(MODE_TEST, 64'h3000_0000_0000_0000, 7'd0,
                   1'b0, 1'b0, 1'b0, '0, 1'b0));
    add_row(mk_row(MODE_TEST, 64'hAAAA_AAAA_AAAA_AAAA, 7'd0,
                   1'b0, 1'b0, 1'b0, '0, 1'b0));
    add_row(mk_row(MODE_TEST, 64'h5555_5555_5555_5555, 7'd0,
                   1'b0, 1'b0, 1'b0, '0, 1'b0));
    add_row(mk_row(MODE_CLEAR, 64'h0, 7'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0));
    add_row(mk_row(MODE_TEST, 64'h0, 7'd0, 1'b1, 1'b1, 1'b0, NONE_VIOLATED, 1'b0));
    foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    drain();
    items_sent = 0;

    // random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      load_setting(ec_list[p], br_list[p]);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        // sender gap profile: light, then heavy, then none
        if (items_sent < TOTAL_ITEMS / 3) idle_pct = 7;
        else if (items_sent < 2 * TOTAL_ITEMS / 3) idle_pct = 82;
        else idle_pct = 0;
        if ($urandom_range(99) < 80) begin
          run_sequence();
        end else begin
          it = mk_item(2'($urandom_range(0, 3)), rand_set(),
                       RANK_W'($urandom_range(0, 127)));
          send(it, 1'b0, '0);
        end
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
